// File: hdl/kum_pkg.sv
// Shared types and constants for the union-find spanning-forest core.
// Used by every module under hdl except kum_parent_ram; depends on nothing else.
package kum_pkg;

    // Fixed field widths of the streaming words.
    localparam int NODE_W     = 14;
    localparam int WFIELD_W   = 32;
    localparam int TOTAL_W    = 48;
    localparam int CNT_W      = 15;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 56;

    // Reset value of the node count register.
    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 15'd16384;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_NODES   = 16384;
    localparam int DEF_WEIGHT_BITS = 32;

    // Commands from the sequencer to the forest-weight accumulator.
    typedef struct packed {
        logic clear;
        logic add;
    } kum_acc_cmd_t;

    // Finished edge result handed from the sequencer to the output register.
    typedef struct packed {
        logic valid;
        logic taken;
    } kum_res_t;

endpackage

// File: hdl/kum_parent_ram.sv
// Parent table memory: one write port and one read port, registered read data.
// Depends on nothing; sized by the DEPTH and ADDR_W parameters.
module kum_parent_ram #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ADDR_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ADDR_W-1:0] rd_data
);

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/kum_accum.sv
// Saturating 48-bit forest-weight accumulator with its saturated flag.
// Depends on kum_pkg for the command struct and the total width.
module kum_accum #(
    parameter int WEIGHT_BITS = kum_pkg::DEF_WEIGHT_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  kum_pkg::kum_acc_cmd_t        cmd,
    input  logic [WEIGHT_BITS-1:0]       weight,
    output logic [kum_pkg::TOTAL_W-1:0]  total,
    output logic                         saturated
);

    localparam int TW = kum_pkg::TOTAL_W;

    logic [TW-1:0] total_reg, total_next;
    logic          sat_reg, sat_next;
    logic [TW:0]   sum;

    // One wide add; the carry out or an all-ones sum means the total is pinned.
    always_comb begin
        sum        = {1'b0, total_reg} + (TW + 1)'(weight);
        total_next = total_reg;
        sat_next   = sat_reg;
        if (cmd.clear) begin
            total_next = '0;
            sat_next   = 1'b0;
        end else if (cmd.add) begin
            if (sum[TW] || (sum[TW-1:0] == {TW{1'b1}})) begin
                total_next = {TW{1'b1}};
                sat_next   = 1'b1;
            end else begin
                total_next = sum[TW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            sat_reg   <= 1'b0;
        end else begin
            total_reg <= total_next;
            sat_reg   <= sat_next;
        end
    end

    assign total     = total_reg;
    assign saturated = sat_reg;

endmodule

// File: hdl/kum_ctrl.sv
// Sequencer for the parent table: clearing sweeps, root walks with path
// compression, and the final link. Depends on kum_pkg.
module kum_ctrl #(
    parameter int MAX_NODES   = kum_pkg::DEF_MAX_NODES,
    parameter int WEIGHT_BITS = kum_pkg::DEF_WEIGHT_BITS,
    parameter int IDX_W       = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [kum_pkg::CNT_W-1:0]     node_count,
    // Edge word from the input channel.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_start,
    input  logic [kum_pkg::NODE_W-1:0]    in_u,
    input  logic [kum_pkg::NODE_W-1:0]    in_v,
    input  logic [kum_pkg::WFIELD_W-1:0]  in_weight,
    // Parent memory ports.
    output logic                          mem_we,
    output logic [IDX_W-1:0]              mem_waddr,
    output logic [IDX_W-1:0]              mem_wdata,
    output logic [IDX_W-1:0]              mem_raddr,
    input  logic [IDX_W-1:0]              mem_rdata,
    // Accumulator control.
    output kum_pkg::kum_acc_cmd_t         acc_cmd,
    output logic [WEIGHT_BITS-1:0]        acc_weight,
    // Result hand-off.
    input  logic                          out_free,
    output kum_pkg::kum_res_t             res
);

    localparam int LIM_W = $clog2(MAX_NODES + 1);
    localparam int CW    = (LIM_W > kum_pkg::CNT_W) ? LIM_W : kum_pkg::CNT_W;

    typedef enum logic [3:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_RUN_CLR,
        ST_EDGE,
        ST_FIND,
        ST_CSTART,
        ST_COMP,
        ST_NEXT,
        ST_RESULT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]          clr_end_reg, clr_end_next;
    logic [IDX_W-1:0]       u_reg, u_next;
    logic [IDX_W-1:0]       v_reg, v_next;
    logic [WEIGHT_BITS-1:0] weight_reg, weight_next;
    logic                   in_range_reg, in_range_next;
    logic                   side_reg, side_next;
    logic [IDX_W-1:0]       node_reg, node_next;
    logic [IDX_W-1:0]       walk_reg, walk_next;
    logic [IDX_W-1:0]       root_reg, root_next;
    logic [IDX_W-1:0]       root_u_reg, root_u_next;
    logic [IDX_W-1:0]       cur_reg, cur_next;
    logic                   taken_reg, taken_next;

    logic [CW-1:0]          cnt_ext;
    logic [CW-1:0]          limit;
    logic [CW-1:0]          u_ext;
    logic [CW-1:0]          v_ext;

    // Node count above the table depth acts as the full depth.
    always_comb begin
        cnt_ext = CW'(node_count);
        limit   = (cnt_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : cnt_ext;
        u_ext   = CW'(in_u);
        v_ext   = CW'(in_v);
    end

    // Next-state and memory access logic.
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_end_next  = clr_end_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        weight_next   = weight_reg;
        in_range_next = in_range_reg;
        side_next     = side_reg;
        node_next     = node_reg;
        walk_next     = walk_reg;
        root_next     = root_reg;
        root_u_next   = root_u_reg;
        cur_next      = cur_reg;
        taken_next    = taken_reg;

        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg[IDX_W-1:0];
        mem_wdata = clr_cnt_reg[IDX_W-1:0];
        mem_raddr = walk_reg;
        acc_cmd   = '0;
        res.valid = 1'b0;
        res.taken = taken_reg;

        unique case (state_reg) inside
            // Sweep entries so that each points to itself.
            ST_INIT_CLR, ST_RUN_CLR: begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg + CW'(1) == clr_end_reg) begin
                    state_next = (state_reg == ST_INIT_CLR) ? ST_IDLE : ST_EDGE;
                end
            end

            // Take one edge word.
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    u_next        = u_ext[IDX_W-1:0];
                    v_next        = v_ext[IDX_W-1:0];
                    weight_next   = in_weight[WEIGHT_BITS-1:0];
                    in_range_next = (u_ext < limit) && (v_ext < limit);
                    taken_next    = 1'b0;
                    if (in_start) begin
                        acc_cmd.clear = 1'b1;
                        clr_cnt_next  = '0;
                        clr_end_next  = limit;
                        state_next    = (limit == '0) ? ST_EDGE : ST_RUN_CLR;
                    end else begin
                        state_next = ST_EDGE;
                    end
                end
            end

            // Start the root walk from node_u, or skip an out-of-range edge.
            ST_EDGE: begin
                if (in_range_reg) begin
                    mem_raddr  = u_reg;
                    walk_next  = u_reg;
                    node_next  = u_reg;
                    side_next  = 1'b0;
                    state_next = ST_FIND;
                end else begin
                    state_next = ST_RESULT;
                end
            end

            // One hop per cycle: the read data is the parent of walk_reg.
            ST_FIND: begin
                if (mem_rdata == walk_reg) begin
                    root_next  = walk_reg;
                    cur_next   = node_reg;
                    state_next = ST_CSTART;
                end else begin
                    mem_raddr = mem_rdata;
                    walk_next = mem_rdata;
                end
            end

            // Begin the compression pass unless the start node is the root.
            ST_CSTART: begin
                if (cur_reg == root_reg) begin
                    state_next = ST_NEXT;
                end else begin
                    mem_raddr  = cur_reg;
                    state_next = ST_COMP;
                end
            end

            // Point cur at the root and read its old parent in the same cycle.
            // The two addresses differ because cur is not a root.
            ST_COMP: begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                mem_wdata = root_reg;
                cur_next  = mem_rdata;
                if (mem_rdata == root_reg) begin
                    state_next = ST_NEXT;
                end else begin
                    mem_raddr = mem_rdata;
                end
            end

            // After node_u, walk node_v; after node_v, link the two roots.
            ST_NEXT: begin
                if (!side_reg) begin
                    root_u_next = root_reg;
                    side_next   = 1'b1;
                    node_next   = v_reg;
                    walk_next   = v_reg;
                    mem_raddr   = v_reg;
                    state_next  = ST_FIND;
                end else begin
                    if (root_u_reg != root_reg) begin
                        mem_we      = 1'b1;
                        mem_waddr   = root_u_reg;
                        mem_wdata   = root_reg;
                        acc_cmd.add = 1'b1;
                        taken_next  = 1'b1;
                    end
                    state_next = ST_RESULT;
                end
            end

            // Hand the result over once the output register has room.
            ST_RESULT: begin
                res.valid = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign acc_weight = weight_reg;

    // State and sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT_CLR;
            clr_cnt_reg <= '0;
            clr_end_reg <= CW'(MAX_NODES);
            taken_reg   <= 1'b0;
            side_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_end_reg <= clr_end_next;
            taken_reg   <= taken_next;
            side_reg    <= side_next;
        end
        u_reg        <= u_next;
        v_reg        <= v_next;
        weight_reg   <= weight_next;
        in_range_reg <= in_range_next;
        node_reg     <= node_next;
        walk_reg     <= walk_next;
        root_reg     <= root_next;
        root_u_reg   <= root_u_next;
        cur_reg      <= cur_next;
    end

endmodule

// File: hdl/kruskal_union_find_mst_core.sv
// An accepted edge word walks node_u, then node_v, to its root, pointing each node it passes
// at that root, and links the two roots if they differ; an edge with an endpoint out of range
// skips the walks. A new edge word is taken only once the last result word is loaded. A start
// flag first clears the total and the parent entries in use; a held result word stalls.
// Reset (aresetn low, synchronous) zeroes the total, sets the node count to 16384, then
// sweeps the whole parent table before the first edge word is taken.
module kruskal_union_find_mst_core #(
    parameter int MAX_NODES   = kum_pkg::DEF_MAX_NODES,
    parameter int WEIGHT_BITS = kum_pkg::DEF_WEIGHT_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: node_count.
    input  logic                            cfg_wen,
    input  logic [kum_pkg::CNT_W-1:0]       cfg_wdata,
    // Edge words.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kum_pkg::S_TDATA_W-1:0]   s_tdata,   // node_u, node_v, edge_weight, pad
    input  logic                            s_tuser,   // start_run
    // Result words.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kum_pkg::M_TDATA_W-1:0]   m_tdata    // edge_taken, forest_weight,
                                                       // total_saturated, pad
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int NW    = kum_pkg::NODE_W;
    localparam int TW    = kum_pkg::TOTAL_W;

    logic [kum_pkg::CNT_W-1:0] node_count_reg;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic [IDX_W-1:0]          mem_wdata;
    logic [IDX_W-1:0]          mem_raddr;
    logic [IDX_W-1:0]          mem_rdata;
    kum_pkg::kum_acc_cmd_t     acc_cmd;
    logic [WEIGHT_BITS-1:0]    acc_weight;
    logic [TW-1:0]             total;
    logic                      saturated;
    kum_pkg::kum_res_t         res;
    logic                      out_free;

    logic                      m_valid_reg;
    logic                      m_taken_reg;
    logic [TW-1:0]             m_total_reg;
    logic                      m_sat_reg;

    // Node count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= kum_pkg::NODE_COUNT_RST;
        end else if (cfg_wen) begin
            node_count_reg <= cfg_wdata;
        end
    end

    kum_parent_ram #(
        .DEPTH  (MAX_NODES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    kum_accum #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (acc_cmd),
        .weight    (acc_weight),
        .total     (total),
        .saturated (saturated)
    );

    kum_ctrl #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .node_count (node_count_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_start   (s_tuser),
        .in_u       (s_tdata[NW-1:0]),
        .in_v       (s_tdata[2*NW-1:NW]),
        .in_weight  (s_tdata[2*NW+kum_pkg::WFIELD_W-1:2*NW]),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .acc_cmd    (acc_cmd),
        .acc_weight (acc_weight),
        .out_free   (out_free),
        .res        (res)
    );

    // Output register: the sequencer moves on as soon as the word is loaded.
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res.valid;
        end
        if (out_free && res.valid) begin
            m_taken_reg <= res.taken;
            m_total_reg <= total;
            m_sat_reg   <= saturated;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(kum_pkg::M_TDATA_W - TW - 2)'(0), m_sat_reg, m_total_reg, m_taken_reg};

endmodule
